// ----- src/assert_macros.svh -----
// Assertion macros for the checker file of the project, drd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// A stalled word must stay valid and keep its payload on the next edge.
`define ASSERT_STALL_HOLD(lbl, clk, rst, vld, rdy, sig) \
   lbl: assert property (@(posedge clk) disable iff (rst) \
      ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
      else $error("stalled word changed");

`endif

// ----- src/drd_pkg.sv -----
// Types and constants of the display reply deframer.
`default_nettype none

package drd_pkg;

   localparam int BUFFER_BYTES = 32;
   localparam int LEN_W        = 6;
   localparam int IDX_W        = $clog2(BUFFER_BYTES);
   localparam int CNT_W        = ($clog2(BUFFER_BYTES + 1) > LEN_W) ?
                                 $clog2(BUFFER_BYTES + 1) : LEN_W;

   localparam logic [7:0] TERM_BYTE = 8'hff;
   localparam logic [1:0] TERM_RUN  = 2'd3;

   localparam logic [7:0] STATUS_LOW_RESET  = 8'd0;
   localparam logic [7:0] STATUS_HIGH_RESET = 8'd35;
   localparam logic [7:0] TOUCH_CODE_RESET  = 8'd101;
   localparam logic [7:0] PAGE_CODE_RESET   = 8'd102;

   typedef enum logic [1:0] {
      CSR_STATUS_LOW  = 2'd0,
      CSR_STATUS_HIGH = 2'd1,
      CSR_TOUCH_CODE  = 2'd2,
      CSR_PAGE_CODE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] status_code_low;
      logic [7:0] status_code_high;
      logic [7:0] touch_code;
      logic [7:0] page_code;
   } cfg_type;

   typedef struct packed {
      logic             packet_done;
      logic [LEN_W-1:0] packet_length;
      logic             overrun;
      logic [7:0]       last_status;
      logic             touch_flag;
      logic             page_event_flag;
      logic [7:0]       page_number;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/drd_req_if.sv -----
// Handshake channels of the display reply deframer: received bytes and results.
`default_nettype none

interface drd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface drd_rsp_if;
   logic       valid;
   logic       ready;
   logic       packet_done;
   logic [5:0] packet_length;
   logic       overrun;
   logic [7:0] last_status;
   logic       touch_flag;
   logic       page_event_flag;
   logic [7:0] page_number;

   modport source (output valid, output packet_done, output packet_length,
                   output overrun, output last_status, output touch_flag,
                   output page_event_flag, output page_number, input ready);
   modport sink   (input valid, input packet_done, input packet_length,
                   input overrun, input last_status, input touch_flag,
                   input page_event_flag, input page_number, output ready);
endinterface

`default_nettype wire

// ----- src/drd_framer.sv -----
// Framing state and packet classification, advanced once per accepted byte.
`default_nettype none

module drd_framer
   import drd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output rsp_type         result
);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [1:0]       term_count_ff, term_count_in;
   logic [7:0]       first_byte_ff, first_byte_in;
   logic [7:0]       second_byte_ff, second_byte_in;
   logic [7:0]       status_ff, status_in;
   logic             touched_ff, touched_in;
   logic             page_event_ff, page_event_in;
   logic [7:0]       page_ff, page_in;

   logic [CNT_W-1:0] idx_next;
   logic [1:0]       term_run;
   logic             is_term;
   logic             done;
   logic             full;
   logic             in_range;

   always_comb begin
      idx_next       = CNT_W'(byte_index_ff) + CNT_W'(1);
      first_byte_in  = (byte_index_ff == '0) ? rx_byte : first_byte_ff;
      second_byte_in = (byte_index_ff == IDX_W'(1)) ? rx_byte : second_byte_ff;
      is_term        = (rx_byte == TERM_BYTE);
      term_run       = term_count_ff + 2'd1;
      done           = is_term && (term_run == TERM_RUN);
      full           = !done && (idx_next >= CNT_W'(BUFFER_BYTES));

      byte_index_in  = (done || full) ? '0 : idx_next[IDX_W-1:0];
      term_count_in  = (done || full || !is_term) ? 2'd0 : term_run;

      in_range       = (first_byte_in >= cfg.status_code_low) &&
                       (first_byte_in <= cfg.status_code_high);

      status_in      = status_ff;
      touched_in     = touched_ff;
      page_event_in  = page_event_ff;
      page_in        = page_ff;
      if (done) begin
         status_in = first_byte_in;
         // The status range wins over the touch code, which wins over the page code.
         priority if (in_range) begin
            touched_in    = 1'b0;
            page_event_in = 1'b0;
         end else if (first_byte_in == cfg.touch_code) begin
            touched_in    = 1'b1;
            page_event_in = 1'b0;
         end else if (first_byte_in == cfg.page_code) begin
            touched_in    = 1'b0;
            page_event_in = 1'b1;
            page_in       = second_byte_in;
         end else begin
            touched_in    = touched_ff;
         end
      end

      result.packet_done     = done;
      result.packet_length   = done ? idx_next[LEN_W-1:0] : '0;
      result.overrun         = full;
      result.last_status     = status_in;
      result.touch_flag      = touched_in;
      result.page_event_flag = page_event_in;
      result.page_number     = page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         term_count_ff  <= 2'd0;
         first_byte_ff  <= 8'd0;
         second_byte_ff <= 8'd0;
         status_ff      <= 8'd0;
         touched_ff     <= 1'b0;
         page_event_ff  <= 1'b0;
         page_ff        <= 8'd0;
      end else if (advance) begin
         byte_index_ff  <= byte_index_in;
         term_count_ff  <= term_count_in;
         first_byte_ff  <= first_byte_in;
         second_byte_ff <= second_byte_in;
         status_ff      <= status_in;
         touched_ff     <= touched_in;
         page_event_ff  <= page_event_in;
         page_ff        <= page_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/display_reply_deframer_top.sv -----
// The display reply deframer takes one received byte per word on req_ch and
// returns exactly one result word per byte on rsp_ch, in the cycle after the
// byte is accepted. A byte can be accepted in every cycle; the single result
// register sets the rate, so req_ch.ready drops only while that register holds
// a word that the sink is not taking in the same cycle. Packets end with three
// consecutive 0xff bytes and hold at most 32 bytes. The user writes the four
// code registers via the csr_ port only with no byte in flight; not enforced.
`default_nettype none

module display_reply_deframer_top
   import drd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   drd_req_if.sink         req_ch,
   drd_rsp_if.source       rsp_ch,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   cfg_type cfg_ff;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   rsp_type result;
   logic    accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.status_code_low  <= STATUS_LOW_RESET;
         cfg_ff.status_code_high <= STATUS_HIGH_RESET;
         cfg_ff.touch_code       <= TOUCH_CODE_RESET;
         cfg_ff.page_code        <= PAGE_CODE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_STATUS_LOW:  cfg_ff.status_code_low  <= csr_wdata;
            CSR_STATUS_HIGH: cfg_ff.status_code_high <= csr_wdata;
            CSR_TOUCH_CODE:  cfg_ff.touch_code       <= csr_wdata;
            CSR_PAGE_CODE:   cfg_ff.page_code        <= csr_wdata;
         endcase
      end
   end

   drd_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .rx_byte (req_ch.rx_byte),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.packet_done     = rsp_data_ff.packet_done;
   assign rsp_ch.packet_length   = rsp_data_ff.packet_length;
   assign rsp_ch.overrun         = rsp_data_ff.overrun;
   assign rsp_ch.last_status     = rsp_data_ff.last_status;
   assign rsp_ch.touch_flag      = rsp_data_ff.touch_flag;
   assign rsp_ch.page_event_flag = rsp_data_ff.page_event_flag;
   assign rsp_ch.page_number     = rsp_data_ff.page_number;

endmodule

`default_nettype wire

// ----- src/drd_checker.sv -----
// Port checker of the display reply deframer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module drd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       packet_done,
   input wire logic [5:0] packet_length,
   input wire logic       overrun,
   input wire logic [7:0] last_status,
   input wire logic       touch_flag,
   input wire logic       page_event_flag,
   input wire logic [7:0] page_number
);

   // A closed packet carries its length, which holds at least the three terminators.
   `ASSERT_ALWAYS(a_len_iff_done, clock, reset, !rsp_valid || (packet_done ? (packet_length >= 6'd3) : (packet_length == 6'd0)))
   // A byte never both closes a packet and overruns the buffer.
   `ASSERT_ALWAYS(a_done_excl_overrun, clock, reset, !rsp_valid || !(packet_done && overrun))
   // Classification never leaves both event flags set.
   `ASSERT_ALWAYS(a_flags_excl, clock, reset, !rsp_valid || !(touch_flag && page_event_flag))
   `ASSERT_STALL_HOLD(a_rsp_hold, clock, reset, rsp_valid, rsp_ready, {packet_done, packet_length, overrun, last_status, touch_flag, page_event_flag, page_number})

endmodule

bind display_reply_deframer_top drd_checker u_drd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .packet_done     (rsp_ch.packet_done),
   .packet_length   (rsp_ch.packet_length),
   .overrun         (rsp_ch.overrun),
   .last_status     (rsp_ch.last_status),
   .touch_flag      (rsp_ch.touch_flag),
   .page_event_flag (rsp_ch.page_event_flag),
   .page_number     (rsp_ch.page_number)
);

`default_nettype wire
